// ===== hdl/jbt_pkg.sv =====
// ----------------------------------------------------------------------------
// jbt_pkg
// shared types, codes, character constants and lookup functions of the
// json byte tokenizer
// ----------------------------------------------------------------------------
package jbt_pkg;

  // token kinds
  localparam logic [3:0] TK_LBRACE = 4'd0;
  localparam logic [3:0] TK_RBRACE = 4'd1;
  localparam logic [3:0] TK_LBRACK = 4'd2;
  localparam logic [3:0] TK_RBRACK = 4'd3;
  localparam logic [3:0] TK_COLON  = 4'd4;
  localparam logic [3:0] TK_COMMA  = 4'd5;
  localparam logic [3:0] TK_STRING = 4'd6;
  localparam logic [3:0] TK_NUMBER = 4'd7;
  localparam logic [3:0] TK_TRUE   = 4'd8;
  localparam logic [3:0] TK_NONE   = 4'd0;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNEXP    = 2'd1;
  localparam logic [1:0] ERR_ESCAPE   = 2'd2;
  localparam logic [1:0] ERR_ESC_EOT  = 2'd3;

  // literal kinds
  localparam logic [1:0] LK_TRUE  = 2'd0;
  localparam logic [1:0] LK_FALSE = 2'd1;
  localparam logic [1:0] LK_NULL  = 2'd2;

  // characters
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LF     = 8'h0A;

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef enum logic [2:0] {
    M_IDLE,
    M_STR,
    M_ESC,
    M_INT,
    M_FRAC,
    M_LIT
  } jbt_mode_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic       char_valid;
    logic [7:0] char_value;
    logic       token_done;
    logic [1:0] error_code;
    logic       run_last;
  } jbt_res_t;

  // one queue entry holds every result of one byte
  typedef struct packed {
    logic     two;
    jbt_res_t res0;
    jbt_res_t res1;
  } jbt_entry_t;

  function automatic jbt_res_t mk_res(input logic [3:0] kind, input logic cv,
                                      input logic [7:0] val, input logic done,
                                      input logic [1:0] err);
    jbt_res_t r;
    r.token_kind = kind;
    r.char_valid = cv;
    r.char_value = val;
    r.token_done = done;
    r.error_code = err;
    r.run_last   = 1'b0;
    return r;
  endfunction

  function automatic jbt_res_t err_res(input logic [1:0] err);
    return mk_res(TK_NONE, 1'b0, 8'h00, 1'b0, err);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return b inside {CH_SPACE, [CH_TAB:CH_CR]};
  endfunction

  // {ok, decoded byte}
  function automatic logic [8:0] unescape(input logic [7:0] b);
    logic [8:0] r;
    case (b)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      CH_B:      r = {1'b1, CH_BS};
      CH_F:      r = {1'b1, CH_FF};
      CH_N:      r = {1'b1, CH_LF};
      CH_R:      r = {1'b1, CH_CR};
      CH_T:      r = {1'b1, CH_TAB};
      default:   r = 9'h000;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] kind);
    logic [2:0] n;
    case (kind)
      LK_TRUE:  n = 3'd4;
      LK_FALSE: n = 3'd5;
      LK_NULL:  n = 3'd4;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] lit_char(input logic [1:0] kind, input logic [2:0] idx);
    logic [7:0] c;
    case ({kind, idx})
      {LK_TRUE,  3'd0}: c = CH_T;
      {LK_TRUE,  3'd1}: c = CH_R;
      {LK_TRUE,  3'd2}: c = CH_U;
      {LK_TRUE,  3'd3}: c = CH_E;
      {LK_FALSE, 3'd0}: c = CH_F;
      {LK_FALSE, 3'd1}: c = CH_A;
      {LK_FALSE, 3'd2}: c = CH_L;
      {LK_FALSE, 3'd3}: c = CH_S;
      {LK_FALSE, 3'd4}: c = CH_E;
      {LK_NULL,  3'd0}: c = CH_N;
      {LK_NULL,  3'd1}: c = CH_U;
      {LK_NULL,  3'd2}: c = CH_L;
      {LK_NULL,  3'd3}: c = CH_L;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/jbt_if.sv =====
// ----------------------------------------------------------------------------
// jbt_if
// valid/ready channels of the tokenizer: text bytes in, token words out
// ----------------------------------------------------------------------------
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jbt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic       char_valid;
  logic [7:0] char_value;
  logic       token_done;
  logic [1:0] error_code;
  logic       run_last;

  modport source (output valid, output token_kind, output char_valid, output char_value,
                  output token_done, output error_code, output run_last, input ready);
  modport sink (input valid, input token_kind, input char_valid, input char_value,
                input token_done, input error_code, input run_last, output ready);
endinterface

// ===== hdl/jbt_front.sv =====
// ----------------------------------------------------------------------------
// jbt_front
// lexer state machine: takes one byte per cycle while the queue is not full, builds its results
// ----------------------------------------------------------------------------
module jbt_front
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  jbt_in_if.sink      in_chan,
  input  logic        q_full,
  output logic        q_push,
  output jbt_entry_t  q_entry
);

  typedef struct packed {
    logic       has;
    logic       fail;
    jbt_res_t   res;
    jbt_mode_t  mode;
    logic [1:0] lkind;
  } jbt_idle_t;

  jbt_mode_t  mode_r, mode_nxt;
  logic [1:0] lkind_r, lkind_nxt;
  logic [2:0] lidx_r, lidx_nxt;
  logic       hold_r, hold_nxt;

  logic       acc;
  logic [7:0] b;
  logic       eot;
  logic [8:0] esc;
  logic       num_cont;
  logic       lit_match;
  logic       lit_fin;
  jbt_idle_t  idle_d;
  jbt_res_t   r0, r1;
  logic       has0, has1;

  // handling of a byte outside any token
  function automatic jbt_idle_t idle_decode(input logic [7:0] c, input logic last);
    jbt_idle_t d;
    d.has   = 1'b0;
    d.fail  = 1'b0;
    d.res   = err_res(ERR_NONE);
    d.mode  = M_IDLE;
    d.lkind = LK_TRUE;
    case (c)
      CH_LBRACE: begin d.has = 1'b1; d.res = mk_res(TK_LBRACE, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_RBRACE: begin d.has = 1'b1; d.res = mk_res(TK_RBRACE, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_LBRACK: begin d.has = 1'b1; d.res = mk_res(TK_LBRACK, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_RBRACK: begin d.has = 1'b1; d.res = mk_res(TK_RBRACK, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_COLON:  begin d.has = 1'b1; d.res = mk_res(TK_COLON, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_COMMA:  begin d.has = 1'b1; d.res = mk_res(TK_COMMA, 1'b0, 8'h00, 1'b1, ERR_NONE); end
      CH_QUOTE: begin
        d.mode = M_STR;
        // opening quote as last byte: lone string end
        d.has  = last;
        d.res  = mk_res(TK_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
      end
      default: begin
        if (is_space(c)) begin
          d.has = 1'b0;
        end else if (is_digit(c) || c == CH_MINUS) begin
          d.mode = M_INT;
          d.has  = 1'b1;
          d.res  = mk_res(TK_NUMBER, 1'b1, c, last, ERR_NONE);
        end else if (c == CH_T || c == CH_F || c == CH_N) begin
          if (last) begin
            d.has  = 1'b1;
            d.fail = 1'b1;
            d.res  = err_res(ERR_UNEXP);
          end else begin
            d.mode  = M_LIT;
            d.lkind = (c == CH_T) ? LK_TRUE : ((c == CH_F) ? LK_FALSE : LK_NULL);
          end
        end else begin
          d.has  = 1'b1;
          d.fail = 1'b1;
          d.res  = err_res(ERR_UNEXP);
        end
      end
    endcase
    return d;
  endfunction

  assign in_chan.ready = !q_full;
  assign acc       = in_chan.valid && !q_full;
  assign b         = in_chan.text_byte;
  assign eot       = in_chan.end_of_text;
  assign esc       = unescape(b);
  assign num_cont  = is_digit(b) || (b == CH_POINT && mode_r == M_INT);
  assign lit_match = (lidx_r < lit_len(lkind_r)) && (b == lit_char(lkind_r, lidx_r));
  assign lit_fin   = (lidx_r + 3'd1) == lit_len(lkind_r);
  assign idle_d    = idle_decode(b, eot);

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    lkind_nxt = lkind_r;
    lidx_nxt  = lidx_r;
    hold_nxt  = hold_r;
    if (acc) begin
      if (!hold_r) begin
        case (mode_r)
          M_STR: begin
            if (b == CH_QUOTE) begin
              mode_nxt = M_IDLE;
            end else if (b == CH_BSLASH) begin
              if (eot) hold_nxt = 1'b1;
              else     mode_nxt = M_ESC;
            end
          end
          M_ESC: begin
            if (esc[8]) mode_nxt = M_STR;
            else        hold_nxt = 1'b1;
          end
          M_INT, M_FRAC: begin
            if (num_cont) begin
              if (b == CH_POINT) mode_nxt = M_FRAC;
            end else begin
              mode_nxt  = idle_d.mode;
              lkind_nxt = idle_d.lkind;
              lidx_nxt  = 3'd1;
              hold_nxt  = idle_d.fail;
            end
          end
          M_LIT: begin
            if (lit_match) begin
              lidx_nxt = lidx_r + 3'd1;
              if (lit_fin)  mode_nxt = M_IDLE;
              else if (eot) hold_nxt = 1'b1;
            end else begin
              hold_nxt = 1'b1;
            end
          end
          default: begin
            mode_nxt  = idle_d.mode;
            lkind_nxt = idle_d.lkind;
            lidx_nxt  = 3'd1;
            hold_nxt  = idle_d.fail;
          end
        endcase
      end
      // the last byte of a document returns everything to reset
      if (eot) begin
        mode_nxt  = M_IDLE;
        lkind_nxt = LK_TRUE;
        lidx_nxt  = 3'd0;
        hold_nxt  = 1'b0;
      end
    end
  end

  // results of the current byte
  always_comb begin
    r0   = err_res(ERR_NONE);
    r1   = err_res(ERR_NONE);
    has0 = 1'b0;
    has1 = 1'b0;
    case (mode_r)
      M_STR: begin
        has0 = 1'b1;
        if (b == CH_QUOTE) begin
          r0 = mk_res(TK_STRING, 1'b0, 8'h00, 1'b1, ERR_NONE);
        end else if (b == CH_BSLASH) begin
          has0 = eot;
          r0   = err_res(ERR_ESC_EOT);
        end else begin
          r0 = mk_res(TK_STRING, 1'b1, b, eot, ERR_NONE);
        end
      end
      M_ESC: begin
        has0 = 1'b1;
        r0   = esc[8] ? mk_res(TK_STRING, 1'b1, esc[7:0], eot, ERR_NONE) : err_res(ERR_ESCAPE);
      end
      M_INT, M_FRAC: begin
        has0 = 1'b1;
        if (num_cont) begin
          r0 = mk_res(TK_NUMBER, 1'b1, b, eot, ERR_NONE);
        end else begin
          // number end, then the byte again as a fresh token start
          r0   = mk_res(TK_NUMBER, 1'b0, 8'h00, 1'b1, ERR_NONE);
          r1   = idle_d.res;
          has1 = idle_d.has;
        end
      end
      M_LIT: begin
        if (lit_match) begin
          has0 = lit_fin || eot;
          r0   = lit_fin ? mk_res(TK_TRUE + {2'b00, lkind_r}, 1'b0, 8'h00, 1'b1, ERR_NONE)
                         : err_res(ERR_UNEXP);
        end else begin
          has0 = 1'b1;
          r0   = err_res(ERR_UNEXP);
        end
      end
      default: begin
        has0 = idle_d.has;
        r0   = idle_d.res;
      end
    endcase
    if (has1) r1.run_last = 1'b1;
    else      r0.run_last = 1'b1;
  end

  assign q_push       = acc && !hold_r && has0;
  assign q_entry.two  = has1;
  assign q_entry.res0 = r0;
  assign q_entry.res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      lkind_r <= LK_TRUE;
      lidx_r  <= 3'd0;
      hold_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      lkind_r <= lkind_nxt;
      lidx_r  <= lidx_nxt;
      hold_r  <= hold_nxt;
    end
  end

endmodule

// ===== hdl/jbt_queue.sv =====
// ----------------------------------------------------------------------------
// jbt_queue
// short fifo of per-byte result entries between front and back
// ----------------------------------------------------------------------------
module jbt_queue
  import jbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  jbt_entry_t wr_entry,
  input  logic       pop,
  output jbt_entry_t head,
  output logic       full,
  output logic       empty
);

  jbt_entry_t         mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/jbt_back.sv =====
// ----------------------------------------------------------------------------
// jbt_back
// unpacks queue entries into single words and holds the output register
// ----------------------------------------------------------------------------
module jbt_back
  import jbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  jbt_entry_t  head,
  input  logic        empty,
  output logic        pop,
  jbt_out_if.source   out_chan
);

  logic     out_valid_r, out_valid_nxt;
  jbt_res_t out_res_r, out_res_nxt;
  logic     sel_r, sel_nxt;
  logic     load;

  // output register may take a new word when empty or being drained
  assign load = !out_valid_r || out_chan.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    sel_nxt       = sel_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !empty;
      if (!empty) begin
        out_res_nxt = sel_r ? head.res1 : head.res0;
        pop         = sel_r || !head.two;
        sel_nxt     = !(sel_r || !head.two);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.token_kind = out_res_r.token_kind;
  assign out_chan.char_valid = out_res_r.char_valid;
  assign out_chan.char_value = out_res_r.char_value;
  assign out_chan.token_done = out_res_r.token_done;
  assign out_chan.error_code = out_res_r.error_code;
  assign out_chan.run_last   = out_res_r.run_last;

endmodule

// ===== hdl/json_byte_tokenizer.sv =====
// ----------------------------------------------------------------------------
// json_byte_tokenizer
// streaming json lexer: one text byte in, zero to two token words out
// ----------------------------------------------------------------------------
// usage
// - in_chan carries text_byte and end_of_text; a byte is taken on a clock
//   edge with valid and ready high. end_of_text marks the final byte of a
//   document and returns the lexer to its start state after that byte
// - out_chan carries one token word per handshake; run_last flags the last
//   word that one input byte produced
// - a byte's results are written into the queue first; each word then
//   enters the output register, from which it leaves on a handshake
// - throughput: one byte per cycle while the queue has room; the output
//   register drains one word per cycle while out_chan is ready, and a
//   byte may yield two words (a number end, then the token that ended it)
// - a four-entry queue of per-byte results sits between the lexer state
//   machine and the output register; when out_chan stalls, input keeps
//   flowing until the queue fills, then in_chan.ready drops
// - after an error word, bytes are dropped until the byte marked last
// - synchronous active-low reset empties the queue and the output register
// ----------------------------------------------------------------------------
module json_byte_tokenizer
  import jbt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  jbt_in_if.sink    in_chan,
  jbt_out_if.source out_chan
);

  // front to queue
  logic       q_push;
  jbt_entry_t q_entry;
  logic       q_full;
  // queue to back
  jbt_entry_t q_head;
  logic       q_empty;
  logic       q_pop;

  // lexer: classification, mode/literal/error state, result building
  jbt_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  // decoupling fifo, one entry per byte with results
  jbt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_entry),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // serializer and output register
  jbt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (q_head),
    .empty    (q_empty),
    .pop      (q_pop),
    .out_chan (out_chan)
  );

  // the front only writes into free queue space
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue written while full");

  // the back only pops an entry that is present
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  // an error word is always the final word of its byte and carries no token
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.error_code != ERR_NONE) |->
      (out_chan.run_last && !out_chan.token_done && !out_chan.char_valid))
    else $error("malformed error word");

  // a word without content carries a zero content byte
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.char_valid) |-> (out_chan.char_value == 8'h00))
    else $error("content byte set without char_valid");

endmodule
